[sv/staggered_grid_stencil_engine_macros.svh]
// Assertion shorthands used by the bound checker.
`ifndef STAGGERED_GRID_STENCIL_ENGINE_MACROS_SVH
`define STAGGERED_GRID_STENCIL_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the block clock, quiet during reset.
`define SGSE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the block clock, quiet during reset.
`define SGSE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sgse_pkg.sv]
package sgse_pkg;

  localparam int DW      = 32;
  localparam int ACC_W   = 46;
  localparam int IN_W    = 3 * DW;
  localparam int OUT_W   = 216;
  localparam int CFG_AW  = 3;

  localparam int MAX_X_DEF = 64;
  localparam int MAX_Y_DEF = 64;
  localparam int MAX_Z_DEF = 256;

  typedef enum logic [CFG_AW-1:0] {
    REG_INV_X  = 3'd0,
    REG_INV_Y  = 3'd1,
    REG_INV_Z  = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5
  } cfg_reg_e;

  // Neighbor taps of the centre point that one stencil evaluation reads.
  localparam int NB_TAPS = 13;
  localparam logic [3:0] TAP_C     = 4'd0;
  localparam logic [3:0] TAP_XM    = 4'd1;
  localparam logic [3:0] TAP_XP    = 4'd2;
  localparam logic [3:0] TAP_YM    = 4'd3;
  localparam logic [3:0] TAP_YP    = 4'd4;
  localparam logic [3:0] TAP_ZM    = 4'd5;
  localparam logic [3:0] TAP_ZP    = 4'd6;
  localparam logic [3:0] TAP_XP_YM = 4'd7;
  localparam logic [3:0] TAP_XP_ZM = 4'd8;
  localparam logic [3:0] TAP_XM_YP = 4'd9;
  localparam logic [3:0] TAP_YP_ZM = 4'd10;
  localparam logic [3:0] TAP_XM_ZP = 4'd11;
  localparam logic [3:0] TAP_YM_ZP = 4'd12;
  localparam logic [3:0] TAP_LAST  = TAP_YM_ZP;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_PLUS = 2'b01;
  localparam logic [1:0] STEP_MINUS = 2'b11;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } tap_off_t;

  function automatic tap_off_t tap_offset(logic [3:0] k);
    tap_off_t o;
    o = '{dx: STEP_NONE, dy: STEP_NONE, dz: STEP_NONE};
    case (k)
      TAP_XM:    o.dx = STEP_MINUS;
      TAP_XP:    o.dx = STEP_PLUS;
      TAP_YM:    o.dy = STEP_MINUS;
      TAP_YP:    o.dy = STEP_PLUS;
      TAP_ZM:    o.dz = STEP_MINUS;
      TAP_ZP:    o.dz = STEP_PLUS;
      TAP_XP_YM: begin o.dx = STEP_PLUS;  o.dy = STEP_MINUS; end
      TAP_XP_ZM: begin o.dx = STEP_PLUS;  o.dz = STEP_MINUS; end
      TAP_XM_YP: begin o.dx = STEP_MINUS; o.dy = STEP_PLUS;  end
      TAP_YP_ZM: begin o.dy = STEP_PLUS;  o.dz = STEP_MINUS; end
      TAP_XM_ZP: begin o.dx = STEP_MINUS; o.dz = STEP_PLUS;  end
      TAP_YM_ZP: begin o.dy = STEP_MINUS; o.dz = STEP_PLUS;  end
      default:   o = '{dx: STEP_NONE, dy: STEP_NONE, dz: STEP_NONE};
    endcase
    return o;
  endfunction

  function automatic logic [3:0] axis_minus(logic [1:0] ax);
    logic [3:0] k;
    case (ax)
      AX_X:    k = TAP_XM;
      AX_Y:    k = TAP_YM;
      default: k = TAP_ZM;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] axis_plus(logic [1:0] ax);
    logic [3:0] k;
    case (ax)
      AX_X:    k = TAP_XP;
      AX_Y:    k = TAP_YP;
      default: k = TAP_ZP;
    endcase
    return k;
  endfunction

endpackage

[sv/sgse_mulq.sv]
// Fixed-point product floor(a * b / 2^16), saturated to the working width.
// The wide operand is split in two halves that share one multiplier.
module sgse_mulq import sgse_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] a_i,
  input  logic signed [DW:0]      b_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] res_o
);

  localparam int HALF = ACC_W / 2;
  localparam int XW   = ACC_W - HALF + 1;
  localparam int PRW  = XW + DW + 1;
  localparam int FW   = ACC_W + DW + 3;

  localparam logic signed [FW-1:0] LIM_HI = (FW'(1) <<< (ACC_W - 1)) - FW'(1);
  localparam logic signed [FW-1:0] LIM_LO = -(FW'(1) <<< (ACC_W - 1));

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI} phase_e;

  phase_e ph_q;
  logic   done_q;

  logic signed [ACC_W-1:0] a_q;
  logic signed [DW:0]      b_q;
  logic signed [PRW-1:0]   pl_q;
  logic signed [ACC_W-1:0] res_q;

  logic signed [XW-1:0]  x;
  logic signed [PRW-1:0] prod;
  logic signed [FW-1:0]  full;
  logic signed [FW-1:0]  shifted;

  always_comb begin
    if (ph_q == PH_LO) begin
      x = $signed({1'b0, a_q[HALF-1:0]});
    end else begin
      x = $signed({a_q[ACC_W-1], a_q[ACC_W-1:HALF]});
    end
    prod    = PRW'(x) * PRW'(b_q);
    full    = (FW'(prod) <<< HALF) + FW'(pl_q);
    shifted = full >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= (ph_q == PH_HI);
      case (ph_q)
        PH_IDLE: if (start_i) ph_q <= PH_LO;
        PH_LO:   ph_q <= PH_HI;
        PH_HI:   ph_q <= PH_IDLE;
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && ph_q == PH_IDLE) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (ph_q == PH_LO) begin
      pl_q <= prod;
    end
    if (ph_q == PH_HI) begin
      if (shifted > LIM_HI) begin
        res_q <= ACC_W'(LIM_HI);
      end else if (shifted < LIM_LO) begin
        res_q <= ACC_W'(LIM_LO);
      end else begin
        res_q <= ACC_W'(shifted);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[sv/staggered_grid_stencil_engine.sv]
// Velocity points (u, v, w) enter one word per accepted input in raster order, x fastest,
// and are written into one window memory holding two planes, two rows and three points.
// A point that completes an interior centre (one plane back) starts an evaluation: the
// thirteen neighbor taps are read from the memory, and then 36 fixed-point products
// run one after another through the one shared 46x33 multiply unit. The block takes
// no input while an evaluation runs; a point that completes no interior centre starts
// none and leaves the block ready for the next point. One output word carries the three Laplacians,
// the three convection terms and the centre position, and it is held in an output
// register so that the next input can be taken while it waits. The user must write sizes
// and reciprocal spacings through the register port only while the block is idle; the block does not enforce this.
module staggered_grid_stencil_engine import sgse_pkg::*; #(
  parameter int MAX_X = MAX_X_DEF,
  parameter int MAX_Y = MAX_Y_DEF,
  parameter int MAX_Z = MAX_Z_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // u_value, v_value, w_value
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // laplace_u, laplace_v, laplace_w, convect_u, convect_v, convect_w,
  // x_pos, y_pos, z_pos, zero fill
  output logic [OUT_W-1:0]  m_axis_tdata_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [DW-1:0]     cfg_wdata_i
);

  localparam int DEPTH = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = AW + 3;
  localparam int CXW   = $clog2(MAX_X);
  localparam int CYW   = $clog2(MAX_Y);
  localparam int CZW   = $clog2(MAX_Z);
  localparam int SXW   = $clog2(MAX_X + 1);
  localparam int SYW   = $clog2(MAX_Y + 1);
  localparam int SZW   = $clog2(MAX_Z + 1);
  localparam int PW    = $clog2(MAX_X * MAX_Y + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_DRAIN, ST_MSTART, ST_MWAIT, ST_FIN
  } state_e;

  // Configuration registers.
  logic [DW-1:0] inv_x_q, inv_y_q, inv_z_q;
  logic [6:0]    size_x_q, size_y_q;
  logic [8:0]    size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q  <= 32'h0001_0000;
      inv_y_q  <= 32'h0001_0000;
      inv_z_q  <= 32'h0001_0000;
      size_x_q <= 7'd64;
      size_y_q <= 7'd64;
      size_z_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_INV_X:  inv_x_q  <= cfg_wdata_i;
        REG_INV_Y:  inv_y_q  <= cfg_wdata_i;
        REG_INV_Z:  inv_z_q  <= cfg_wdata_i;
        REG_SIZE_X: size_x_q <= cfg_wdata_i[6:0];
        REG_SIZE_Y: size_y_q <= cfg_wdata_i[6:0];
        REG_SIZE_Z: size_z_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Sizes in use, clamped to the supported range.
  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [SZW-1:0] sz;
  logic [PW-1:0]  plane_c;

  always_comb begin
    if (size_x_q < 7'd3) begin
      sx = SXW'(3);
    end else if (32'(size_x_q) > MAX_X) begin
      sx = SXW'(MAX_X);
    end else begin
      sx = SXW'(size_x_q);
    end
    if (size_y_q < 7'd3) begin
      sy = SYW'(3);
    end else if (32'(size_y_q) > MAX_Y) begin
      sy = SYW'(MAX_Y);
    end else begin
      sy = SYW'(size_y_q);
    end
    if (size_z_q < 9'd3) begin
      sz = SZW'(3);
    end else if (32'(size_z_q) > MAX_Z) begin
      sz = SZW'(MAX_Z);
    end else begin
      sz = SZW'(size_z_q);
    end
    plane_c = PW'(PW'(sx) * PW'(sy));
  end

  // Control state.
  state_e         state_q;
  logic [CXW-1:0] col_q;
  logic [CYW-1:0] row_q;
  logic [CZW-1:0] pln_q;
  logic [AW-1:0]  wp_q;
  logic [3:0]     tap_q;
  logic           rv_q;
  logic [3:0]     rk_q;
  logic           kind_q;
  logic [1:0]     comp_q;
  logic [1:0]     ax_q;
  logic           half_q;
  logic           m_valid_q;

  // Payload registers.
  logic [AW-1:0]   wp_c_q;
  logic [SXW-1:0]  sx_l_q;
  logic [PW-1:0]   plane_l_q;
  logic [5:0]      pos_x_q, pos_y_q;
  logic [7:0]      pos_z_q;
  logic [IN_W-1:0] rdata_q;
  logic [IN_W-1:0] nb_q [NB_TAPS];
  logic signed [ACC_W-1:0] m1_q;
  logic signed [ACC_W+1:0] acc_q;
  logic [DW-1:0]   work_q [2][3];
  logic [OUT_W-1:0] out_q;

  logic [IN_W-1:0] win_mem [DEPTH];

  logic s_acc;
  logic interior;
  logic last_col, last_row, last_pln;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign interior = (col_q != '0) && (32'(col_q) + 2 <= 32'(sx)) &&
                    (row_q != '0) && (32'(row_q) + 2 <= 32'(sy)) &&
                    (32'(pln_q) >= 2) && (32'(pln_q) + 1 <= 32'(sz));
  assign last_col = (32'(col_q) + 1 >= 32'(sx));
  assign last_row = (32'(row_q) + 1 >= 32'(sy));
  assign last_pln = (32'(pln_q) + 1 >= 32'(sz));

  // Read address of the current tap, relative to the centre's write slot.
  tap_off_t            off;
  logic signed [TW-1:0] addr_t;
  logic [AW-1:0]        raddr;

  always_comb begin
    off    = tap_offset(tap_q);
    addr_t = $signed(TW'(wp_c_q)) + $signed(TW'(DEPTH)) - $signed(TW'(plane_l_q));
    if (off.dx == STEP_PLUS) begin
      addr_t = addr_t + TW'(1);
    end else if (off.dx == STEP_MINUS) begin
      addr_t = addr_t - TW'(1);
    end
    if (off.dy == STEP_PLUS) begin
      addr_t = addr_t + $signed(TW'(sx_l_q));
    end else if (off.dy == STEP_MINUS) begin
      addr_t = addr_t - $signed(TW'(sx_l_q));
    end
    if (off.dz == STEP_PLUS) begin
      addr_t = addr_t + $signed(TW'(plane_l_q));
    end else if (off.dz == STEP_MINUS) begin
      addr_t = addr_t - $signed(TW'(plane_l_q));
    end
    if (addr_t >= $signed(TW'(DEPTH))) begin
      addr_t = addr_t - $signed(TW'(DEPTH));
    end
    raddr = addr_t[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      win_mem[wp_q] <= s_axis_tdata_i;
    end
    rdata_q <= win_mem[raddr];
  end

  // Operand selection for the shared multiply unit.
  logic [DW-1:0] ctr, prv, nxt;
  logic [DW-1:0] t0, t1, t2, t3;
  logic [1:0]    oc;
  logic [3:0]    i1, i2, i3;
  logic          own;
  logic signed [DW+1:0]  avg_sum;
  logic [DW-1:0]         factor;
  logic [DW-1:0]         inv_sel;
  logic signed [ACC_W-1:0] lap_s, conv_d;
  logic signed [ACC_W-1:0] mul_a;
  logic signed [DW:0]      mul_b;
  logic                    mul_done;
  logic signed [ACC_W-1:0] mul_res;
  logic signed [ACC_W+1:0] acc_sum;
  logic [DW-1:0]           acc_sat;

  always_comb begin
    ctr = nb_q[TAP_C][comp_q*DW +: DW];
    prv = nb_q[axis_minus(ax_q)][comp_q*DW +: DW];
    nxt = nb_q[axis_plus(ax_q)][comp_q*DW +: DW];

    // Four-point staggered average of another component.
    own = 1'b0;
    oc  = 2'd0;
    i1  = TAP_C;
    i2  = TAP_C;
    i3  = TAP_C;
    case ({comp_q, ax_q})
      {2'd0, AX_Y}: begin oc = 2'd1; i1 = TAP_XP; i2 = TAP_YM; i3 = TAP_XP_YM; end
      {2'd0, AX_Z}: begin oc = 2'd2; i1 = TAP_XP; i2 = TAP_ZM; i3 = TAP_XP_ZM; end
      {2'd1, AX_X}: begin oc = 2'd0; i1 = TAP_YP; i2 = TAP_XM; i3 = TAP_XM_YP; end
      {2'd1, AX_Z}: begin oc = 2'd2; i1 = TAP_YP; i2 = TAP_ZM; i3 = TAP_YP_ZM; end
      {2'd2, AX_X}: begin oc = 2'd0; i1 = TAP_ZP; i2 = TAP_XM; i3 = TAP_XM_ZP; end
      {2'd2, AX_Y}: begin oc = 2'd1; i1 = TAP_ZP; i2 = TAP_YM; i3 = TAP_YM_ZP; end
      default:      own = 1'b1;
    endcase
    t0 = nb_q[TAP_C][oc*DW +: DW];
    t1 = nb_q[i1][oc*DW +: DW];
    t2 = nb_q[i2][oc*DW +: DW];
    t3 = nb_q[i3][oc*DW +: DW];
    avg_sum = (DW+2)'($signed(t0)) + (DW+2)'($signed(t1)) +
              (DW+2)'($signed(t2)) + (DW+2)'($signed(t3));
    factor  = own ? ctr : avg_sum[DW+1:2];

    case (ax_q)
      AX_X:    inv_sel = inv_x_q;
      AX_Y:    inv_sel = inv_y_q;
      default: inv_sel = inv_z_q;
    endcase

    lap_s  = ACC_W'($signed(prv)) - (ACC_W'($signed(ctr)) <<< 1) + ACC_W'($signed(nxt));
    conv_d = ACC_W'($signed(nxt)) - ACC_W'($signed(prv));

    if (!half_q) begin
      mul_a = kind_q ? conv_d : lap_s;
      mul_b = $signed({1'b0, inv_sel});
    end else begin
      mul_a = kind_q ? (m1_q >>> 1) : m1_q;
      mul_b = kind_q ? (DW+1)'($signed(factor)) : $signed({1'b0, inv_sel});
    end

    acc_sum = acc_q + (ACC_W+2)'(mul_res);
    if (acc_sum > $signed((ACC_W+2)'(32'sh7fff_ffff))) begin
      acc_sat = 32'h7fff_ffff;
    end else if (acc_sum < -$signed((ACC_W+2)'(33'sh0_8000_0000))) begin
      acc_sat = 32'h8000_0000;
    end else begin
      acc_sat = acc_sum[DW-1:0];
    end
  end

  sgse_mulq u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_MSTART),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  logic last_term;
  assign last_term = kind_q && (comp_q == 2'd2) && (ax_q == AX_Z);

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      pln_q     <= '0;
      wp_q      <= '0;
      tap_q     <= '0;
      rv_q      <= 1'b0;
      rk_q      <= '0;
      kind_q    <= 1'b0;
      comp_q    <= '0;
      ax_q      <= '0;
      half_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      rv_q <= (state_q == ST_READ);
      rk_q <= tap_q;
      // In the final state the output valid is handled below.
      if (m_valid_q && m_axis_tready_i && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
            if (last_col) begin
              col_q <= '0;
              if (last_row) begin
                row_q <= '0;
                pln_q <= last_pln ? '0 : pln_q + 1'b1;
              end else begin
                row_q <= row_q + 1'b1;
              end
            end else begin
              col_q <= col_q + 1'b1;
            end
            if (interior) begin
              tap_q   <= '0;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          tap_q <= tap_q + 1'b1;
          if (tap_q == TAP_LAST) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          kind_q  <= 1'b0;
          comp_q  <= '0;
          ax_q    <= AX_X;
          half_q  <= 1'b0;
          state_q <= ST_MSTART;
        end
        ST_MSTART: state_q <= ST_MWAIT;
        ST_MWAIT: begin
          if (mul_done) begin
            half_q  <= ~half_q;
            state_q <= ST_MSTART;
            if (half_q) begin
              if (ax_q == AX_Z) begin
                ax_q <= AX_X;
                if (comp_q == 2'd2) begin
                  comp_q <= '0;
                  kind_q <= 1'b1;
                end else begin
                  comp_q <= comp_q + 1'b1;
                end
              end else begin
                ax_q <= ax_q + 1'b1;
              end
              if (last_term) begin
                state_q <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      wp_c_q    <= wp_q;
      sx_l_q    <= sx;
      plane_l_q <= plane_c;
      pos_x_q   <= 6'(col_q);
      pos_y_q   <= 6'(row_q);
      pos_z_q   <= 8'(pln_q - 1'b1);
    end
    if (rv_q) begin
      nb_q[rk_q] <= rdata_q;
    end
    if (state_q == ST_DRAIN) begin
      acc_q <= '0;
    end
    if (state_q == ST_MWAIT && mul_done) begin
      if (!half_q) begin
        m1_q <= mul_res;
      end else if (ax_q == AX_Z) begin
        work_q[kind_q][comp_q] <= acc_sat;
        acc_q <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (state_q == ST_FIN && (!m_valid_q || m_axis_tready_i)) begin
      out_q <= {4'b0, pos_z_q, pos_y_q, pos_x_q,
                work_q[1][2], work_q[1][1], work_q[1][0],
                work_q[0][2], work_q[0][1], work_q[0][0]};
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

[sv/sgse_checker.sv]
`include "staggered_grid_stencil_engine_macros.svh"

module sgse_checker import sgse_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  // A stalled output word must stay put.
  `SGSE_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o), "output word changed while stalled")

  // A new result appears only after the block stopped taking input to finish it.
  `SGSE_ASSERT_IMP(a_rise_busy, $rose(m_axis_tvalid_o), !$past(s_axis_tready_o),
    "result appeared without an evaluation")

  // Only interior centres are reported.
  `SGSE_ASSERT_IMP(a_interior, m_axis_tvalid_o,
    m_axis_tdata_o[197:192] != 6'd0 && m_axis_tdata_o[203:198] != 6'd0,
    "boundary centre reported")

endmodule

bind staggered_grid_stencil_engine sgse_checker u_sgse_checker (.*);

[sim/stencil_checker.sv]
`timescale 1ns / 100ps

module stencil_checker import sgse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [OUT_W-1:0]  out_data_i,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [DW-1:0]     cfg_wdata_i,
  output int                pending_o,
  output int                fail_count_o
);

  localparam int WIN_DEPTH = 2 * MAX_X_DEF * MAX_Y_DEF + 2 * MAX_X_DEF + 3;
  localparam longint ACC_LIM = 64'sd35184372088831;
  localparam longint LIM32 = 64'sd2147483647;

  int unsigned inv_spacing [3];
  int unsigned size_reg [3];
  int win [3][WIN_DEPTH];
  int wr_ptr, col_cnt, row_cnt, plane_cnt;
  longint geo_sx, geo_plane;
  logic [OUT_W-1:0] expected_words [$];
  int mismatches;

  function automatic longint sat(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim - 1) return -lim - 1;
    return x;
  endfunction

  // floor(a*b / 2^16), split so that no partial product leaves 64 bits.
  function automatic longint mulq(longint a, longint b);
    longint lo, hi;
    lo = b & 64'hFFFF;
    hi = (b - lo) >>> 16;
    return sat(a * hi + ((a * lo) >>> 16), ACC_LIM);
  endfunction

  function automatic longint fetch(int c, int dx, int dy, int dz);
    longint back;
    int idx;
    back = geo_plane - (dz * geo_plane + dy * geo_sx + dx);
    idx = int'((wr_ptr + WIN_DEPTH - back) % WIN_DEPTH);
    return longint'(win[c][idx]);
  endfunction

  function automatic longint inv_of(int ax);
    return longint'({32'd0, inv_spacing[ax]});
  endfunction

  function automatic longint second_diff(int c, int ax);
    int dx, dy, dz;
    longint s;
    dx = (ax == 0);
    dy = (ax == 1);
    dz = (ax == 2);
    s = fetch(c, -dx, -dy, -dz) - 2 * fetch(c, 0, 0, 0) + fetch(c, dx, dy, dz);
    return mulq(mulq(s, inv_of(ax)), inv_of(ax));
  endfunction

  function automatic longint central_diff(int c, int ax);
    int dx, dy, dz;
    dx = (ax == 0);
    dy = (ax == 1);
    dz = (ax == 2);
    return mulq(fetch(c, dx, dy, dz) - fetch(c, -dx, -dy, -dz), inv_of(ax)) >>> 1;
  endfunction

  // Staggered average of the centre and the points at offsets a, b and a+b.
  function automatic longint stag_avg(int c, int ax, int ay, int az, int bx, int by, int bz);
    return (fetch(c, 0, 0, 0) + fetch(c, ax, ay, az) + fetch(c, bx, by, bz)
            + fetch(c, ax + bx, ay + by, az + bz)) >>> 2;
  endfunction

  function automatic longint laplacian(int c);
    return sat(second_diff(c, 0) + second_diff(c, 1) + second_diff(c, 2), LIM32);
  endfunction

  function automatic int clamp_size(int unsigned s, int mx);
    if (s < 3) return 3;
    if (s > mx) return mx;
    return s;
  endfunction

  function automatic int field_lo(int i);
    return (i < 6) ? i * 32 : (i == 6) ? 192 : (i == 7) ? 198 : 204;
  endfunction

  function automatic int field_w(int i);
    return (i < 6) ? 32 : (i == 8) ? 8 : 6;
  endfunction

  function automatic string field_name(int i);
    case (i)
      0: return "laplace_u";
      1: return "laplace_v";
      2: return "laplace_w";
      3: return "convect_u";
      4: return "convect_v";
      5: return "convect_w";
      6: return "x_pos";
      7: return "y_pos";
      default: return "z_pos";
    endcase
  endfunction

  task automatic take_point(logic [IN_W-1:0] d);
    int sx, sy, sz;
    longint r [6];
    logic [OUT_W-1:0] w;
    sx = clamp_size(size_reg[0], MAX_X_DEF);
    sy = clamp_size(size_reg[1], MAX_Y_DEF);
    sz = clamp_size(size_reg[2], MAX_Z_DEF);
    for (int c = 0; c < 3; c++) win[c][wr_ptr] = int'(d[c*32 +: 32]);
    geo_sx = sx;
    geo_plane = longint'(sx) * sy;
    if (col_cnt >= 1 && col_cnt + 2 <= sx && row_cnt >= 1 && row_cnt + 2 <= sy &&
        plane_cnt >= 2 && plane_cnt + 1 <= sz) begin
      for (int c = 0; c < 3; c++) r[c] = laplacian(c);
      r[3] = sat(mulq(central_diff(0, 0), fetch(0, 0, 0, 0))
               + mulq(central_diff(0, 1), stag_avg(1, 1, 0, 0, 0, -1, 0))
               + mulq(central_diff(0, 2), stag_avg(2, 1, 0, 0, 0, 0, -1)), LIM32);
      r[4] = sat(mulq(central_diff(1, 0), stag_avg(0, 0, 1, 0, -1, 0, 0))
               + mulq(central_diff(1, 1), fetch(1, 0, 0, 0))
               + mulq(central_diff(1, 2), stag_avg(2, 0, 1, 0, 0, 0, -1)), LIM32);
      r[5] = sat(mulq(central_diff(2, 0), stag_avg(0, 0, 0, 1, -1, 0, 0))
               + mulq(central_diff(2, 1), stag_avg(1, 0, 0, 1, 0, -1, 0))
               + mulq(central_diff(2, 2), fetch(2, 0, 0, 0)), LIM32);
      w = '0;
      for (int i = 0; i < 6; i++) w[i*32 +: 32] = r[i][31:0];
      w[197:192] = col_cnt[5:0];
      w[203:198] = row_cnt[5:0];
      w[211:204] = 8'(plane_cnt - 1);
      expected_words.push_back(w);
    end
    wr_ptr = (wr_ptr + 1) % WIN_DEPTH;
    col_cnt++;
    if (col_cnt >= sx) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= sy) begin
        row_cnt = 0;
        plane_cnt++;
        if (plane_cnt >= sz) plane_cnt = 0;
      end
    end
  endtask

  task automatic check_word(logic [OUT_W-1:0] act);
    logic [OUT_W-1:0] exp_w;
    logic [31:0] e, a, mask;
    bit bad;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected output word %h", act);
      return;
    end
    exp_w = expected_words.pop_front();
    bad = 0;
    for (int i = 0; i < 9; i++) begin
      mask = (field_w(i) == 32) ? 32'hFFFF_FFFF : ((32'd1 << field_w(i)) - 1);
      e = 32'(exp_w >> field_lo(i)) & mask;
      a = 32'(act >> field_lo(i)) & mask;
      if (e !== a) begin
        bad = 1;
        if (mismatches < 10)
          $display("Mismatch on %s: expected %h, got %h", field_name(i), e, a);
      end
    end
    if (bad) mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_spacing = '{32'h10000, 32'h10000, 32'h10000};
      size_reg = '{64, 64, 256};
      wr_ptr = 0;
      col_cnt = 0;
      row_cnt = 0;
      plane_cnt = 0;
      mismatches = 0;
      expected_words.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_INV_X:  inv_spacing[0] = cfg_wdata_i;
          REG_INV_Y:  inv_spacing[1] = cfg_wdata_i;
          REG_INV_Z:  inv_spacing[2] = cfg_wdata_i;
          REG_SIZE_X: size_reg[0] = cfg_wdata_i & 32'h7F;
          REG_SIZE_Y: size_reg[1] = cfg_wdata_i & 32'h7F;
          REG_SIZE_Z: size_reg[2] = cfg_wdata_i & 32'h1FF;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_point(in_data_i);
      if (out_valid_i && out_ready_i) check_word(out_data_i);
      pending_o <= expected_words.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import sgse_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [DW-1:0]     cfg_wdata_i = '0;

  int pending, fail_count;
  bit tx_idle_en = 1;
  bit rx_idle_en = 1;
  bit hold_go = 0;
  int random_points = 0;

  staggered_grid_stencil_engine dut (.*);

  stencil_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid_i), .in_ready_i(s_axis_tready_o), .in_data_i(s_axis_tdata_i),
    .out_valid_i(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .out_data_i(m_axis_tdata_o),
    .cfg_we_i(cfg_we_i), .cfg_addr_i(cfg_addr_i), .cfg_wdata_i(cfg_wdata_i),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(rx_idle_en && $urandom_range(99) < 30);
      end
    end
  end

  initial begin
    #30ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [31:0] rand_velocity();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
    endcase
  endfunction

  function automatic logic [31:0] rand_inv();
    case ($urandom_range(2))
      0: return 32'h0001_0000;
      1: return $urandom;
      default: return $urandom_range(0, 262144);
    endcase
  endfunction

  function automatic int eff_size(int unsigned s, int mx);
    return (s < 3) ? 3 : (s > mx) ? mx : s;
  endfunction

  task automatic send_word(logic [31:0] u, logic [31:0] v, logic [31:0] w);
    while (tx_idle_en && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {w, v, u};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // A register may only change once the block has gone quiet.
  task automatic wait_quiet();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(int unsigned sx, int unsigned sy, int unsigned sz,
                          logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
    wait_quiet();
    write_reg(REG_INV_X, ix);
    write_reg(REG_INV_Y, iy);
    write_reg(REG_INV_Z, iz);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
  endtask

  task automatic stream_random(int n);
    for (int i = 0; i < n; i++) send_word(rand_velocity(), rand_velocity(), rand_velocity());
  endtask

  initial begin
    int sx, sy, sz;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme values around the one interior centre of a 3x3x3 volume, with
    // the largest, zero and unit reciprocal spacings.
    set_grid(3, 3, 3, 32'hFFFF_FFFF, 32'h0, 32'h0001_0000);
    for (int k = 0; k < 27; k++) begin
      send_word(k == 13 ? 32'h8000_0000 : (k % 2 ? 32'h7FFF_FFFF : 32'h0),
                k == 13 ? 32'h7FFF_FFFF : 32'h8000_0000,
                k % 3 == 0 ? 32'hFFFF_FFFF : (k % 3 == 1 ? 32'd1 : 32'(k) << 16));
    end
    set_grid(3, 3, 3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    stream_random(27);

    // Widest rows (size above range clamps), sender never idle, long output stall.
    set_grid(127, 0, 3, rand_inv(), rand_inv(), rand_inv());
    tx_idle_en = 0;
    hold_go = 1;
    stream_random(64 * 3 * 3);
    tx_idle_en = 1;

    // Narrowest rows and shallowest volume (sizes below range clamp), receiver never idle.
    set_grid(0, 4, 2, rand_inv(), rand_inv(), rand_inv());
    rx_idle_en = 0;
    stream_random(3 * 4 * 3);
    rx_idle_en = 1;

    while (random_points < 30) begin
      sx = $urandom_range(3, 4);
      sy = $urandom_range(3, 4);
      sz = $urandom_range(3, 4);
      set_grid(sx, sy, sz, rand_inv(), rand_inv(), rand_inv());
      stream_random(sx * sy * sz);
      random_points += sx * sy * sz;
    end

    // Deepest volume; only its first planes are streamed.
    set_grid(3, 3, 511, rand_inv(), rand_inv(), rand_inv());
    sz = eff_size(511, MAX_Z_DEF);
    stream_random(3 * 3 * 4);

    wait_quiet();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
